// File: sv/sfcr_pkg.sv
// Shared types, constants and the CRC step for the framed command receiver.
package sfcr_pkg;

  localparam int CONFIG_ENTRIES   = 5;
  localparam int INIT_TABLE_BYTES = 128;

  localparam logic [31:0] HDR_WORD  = 32'h7171_666D;
  localparam logic [7:0]  END_MARK  = 8'hFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam int          BODY_LEN  = 6;

  localparam logic [7:0] CMD_CFG_WRITE  = 8'd1;
  localparam logic [7:0] CMD_RAW_SEND   = 8'd2;
  localparam logic [7:0] CMD_NOP        = 8'd3;
  localparam logic [7:0] CMD_RESET      = 8'd4;
  localparam logic [7:0] CMD_INIT_WRITE = 8'd5;

  typedef enum logic [2:0] {
    ACT_CFG_WRITE  = 3'd0,
    ACT_RAW_SEND   = 3'd1,
    ACT_NOP        = 3'd2,
    ACT_RESET      = 3'd3,
    ACT_INIT_WRITE = 3'd4
  } action_t;

  typedef struct packed {
    logic        done;
    logic        crc_ok;
    logic [7:0]  cmd;
    logic [7:0]  addr;
    logic [31:0] word;
  } frame_msg_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  target;
    logic [31:0] data_value;
    logic        acknowledge;
  } result_t;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: sv/sfcr_frame.sv
// Header search, message collection and running CRC for the command receiver.
module sfcr_frame (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic [7:0]              rx_byte,
  input  logic                    soft_rst,
  output sfcr_pkg::frame_msg_t    msg
);

  logic [23:0] hist_r, hist_nxt;
  logic        synced_r, synced_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        crc_lo_ok_r, crc_lo_ok_nxt;
  logic [7:0]  body_r [sfcr_pkg::BODY_LEN];
  logic [7:0]  body_nxt [sfcr_pkg::BODY_LEN];
  logic        hdr_hit;
  logic        in_body;

  assign hdr_hit = ({hist_r, rx_byte} == sfcr_pkg::HDR_WORD);
  assign in_body = synced_r && (pos_r < 3'(sfcr_pkg::BODY_LEN));

  assign msg.done   = synced_r && (pos_r == 3'd7) && !hdr_hit;
  assign msg.crc_ok = crc_lo_ok_r && (rx_byte == crc_r[15:8]);
  assign msg.cmd    = body_r[0];
  assign msg.addr   = body_r[1];
  assign msg.word   = {body_r[5], body_r[4], body_r[3], body_r[2]};

  always_comb begin
    hist_nxt      = {hist_r[15:0], rx_byte};
    synced_nxt    = synced_r;
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    crc_lo_ok_nxt = crc_lo_ok_r;
    for (int i = 0; i < sfcr_pkg::BODY_LEN; i++) begin
      body_nxt[i] = body_r[i];
      if (in_body && (pos_r == 3'(i))) begin
        body_nxt[i] = rx_byte;
      end
    end
    if (in_body) begin
      crc_nxt = sfcr_pkg::crc16_step(crc_r, rx_byte);
    end
    if (synced_r && (pos_r == 3'd6)) begin
      crc_lo_ok_nxt = (rx_byte == crc_r[7:0]);
    end
    if (synced_r) begin
      if (pos_r == 3'd7) begin
        synced_nxt = 1'b0;
        pos_nxt    = 3'd0;
      end else begin
        pos_nxt = pos_r + 3'd1;
      end
    end
    if (hdr_hit) begin
      synced_nxt = 1'b1;
      pos_nxt    = 3'd0;
      crc_nxt    = 16'h0000;
    end
    if (soft_rst) begin
      hist_nxt   = 24'h000000;
      synced_nxt = 1'b0;
      pos_nxt    = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r   <= 24'h000000;
      synced_r <= 1'b0;
      pos_r    <= 3'd0;
    end else if (en) begin
      hist_r   <= hist_nxt;
      synced_r <= synced_nxt;
      pos_r    <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      crc_r       <= crc_nxt;
      crc_lo_ok_r <= crc_lo_ok_nxt;
      body_r      <= body_nxt;
    end
  end

endmodule

// File: sv/sfcr_decode.sv
// Command decode and init-table sequence tracking for the command receiver.
module sfcr_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  sfcr_pkg::frame_msg_t  msg,
  output logic                  res_vld,
  output sfcr_pkg::result_t     res,
  output logic                  soft_rst
);

  logic [7:0] last_seq_r, last_seq_nxt;
  logic [7:0] seq;
  logic       seq_ok;
  logic       cfg_in_range;
  logic       init_in_range;
  logic       hit;

  assign seq           = msg.word[15:8];
  assign seq_ok        = (seq == 8'd0) || ({1'b0, seq} == ({1'b0, last_seq_r} + 9'd1));
  assign cfg_in_range  = ({1'b0, msg.addr} < 9'(sfcr_pkg::CONFIG_ENTRIES));
  assign init_in_range = ({1'b0, msg.addr} < 9'(sfcr_pkg::INIT_TABLE_BYTES));

  always_comb begin
    hit             = 1'b0;
    res.action      = sfcr_pkg::ACT_NOP;
    res.target      = msg.addr;
    res.data_value  = {24'h000000, msg.word[7:0]};
    res.acknowledge = 1'b1;
    last_seq_nxt    = last_seq_r;
    unique case (msg.cmd)
      sfcr_pkg::CMD_CFG_WRITE: begin
        hit            = cfg_in_range;
        res.action     = sfcr_pkg::ACT_CFG_WRITE;
        res.data_value = msg.word;
      end
      sfcr_pkg::CMD_RAW_SEND: begin
        hit        = 1'b1;
        res.action = sfcr_pkg::ACT_RAW_SEND;
      end
      sfcr_pkg::CMD_NOP: begin
        hit        = 1'b1;
        res.action = sfcr_pkg::ACT_NOP;
      end
      sfcr_pkg::CMD_RESET: begin
        hit             = 1'b1;
        res.action      = sfcr_pkg::ACT_RESET;
        res.acknowledge = 1'b0;
      end
      sfcr_pkg::CMD_INIT_WRITE: begin
        hit        = init_in_range && seq_ok;
        res.action = sfcr_pkg::ACT_INIT_WRITE;
        if (msg.word[23:16] == sfcr_pkg::END_MARK) begin
          res.acknowledge = 1'b1;
          last_seq_nxt    = sfcr_pkg::END_MARK;
        end else begin
          res.acknowledge = 1'b0;
          last_seq_nxt    = seq;
        end
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  assign res_vld  = msg.done && msg.crc_ok && hit;
  assign soft_rst = en && res_vld && (res.action == sfcr_pkg::ACT_RESET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_seq_r <= sfcr_pkg::END_MARK;
    end else if (soft_rst) begin
      last_seq_r <= sfcr_pkg::END_MARK;
    end else if (en && res_vld && (res.action == sfcr_pkg::ACT_INIT_WRITE)) begin
      last_seq_r <= last_seq_nxt;
    end
  end

endmodule

// File: sv/sync_framed_command_receiver_unit.sv
// Top level of the framed command receiver: input register, framing, decode, result register.
// A word accepted into the input register is decoded from it, and its result, if any, is
// loaded into the result register when the word advances out of the input register.
// Throughput: one word per cycle; the input register keeps taking words while a result
// waits in the result register, and stalls only when a new result meets a held one.
// Reset (rst_n low, synchronous) clears history, framing and sequence state; a reset
// command restores the same state at the same edge that registers its result.
module sync_framed_command_receiver_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [7:0]  out_target,
  output logic [31:0] out_data_value,
  output logic        out_acknowledge
);

  logic                 a_vld_r;
  logic [7:0]           a_byte_r;
  logic                 out_valid_r;
  sfcr_pkg::result_t    out_res_r;
  sfcr_pkg::frame_msg_t msg;
  sfcr_pkg::result_t    res;
  logic                 res_vld;
  logic                 soft_rst;
  logic                 out_free;
  logic                 adv;
  logic                 load;

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = a_vld_r && (!res_vld || out_free);
  assign in_stall = a_vld_r && !adv;
  assign load     = in_valid && !in_stall;

  sfcr_frame u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .rx_byte  (a_byte_r),
    .soft_rst (soft_rst),
    .msg      (msg)
  );

  sfcr_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .msg      (msg),
    .res_vld  (res_vld),
    .res      (res),
    .soft_rst (soft_rst)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        a_vld_r <= 1'b1;
      end else if (adv) begin
        a_vld_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= adv && res_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_byte_r <= in_rx_byte;
    end
    if (adv && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_action      = out_res_r.action;
  assign out_target      = out_res_r.target;
  assign out_data_value  = out_res_r.data_value;
  assign out_acknowledge = out_res_r.acknowledge;

  a_reset_no_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.action == sfcr_pkg::ACT_RESET)) |-> !out_res_r.acknowledge)
    else $error("reset result carries an acknowledge");

  a_cfg_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.action == sfcr_pkg::ACT_CFG_WRITE)) |->
      ({1'b0, out_res_r.target} < 9'(sfcr_pkg::CONFIG_ENTRIES)))
    else $error("config write result with out-of-range target");

  a_init_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.action == sfcr_pkg::ACT_INIT_WRITE)) |->
      ({1'b0, out_res_r.target} < 9'(sfcr_pkg::INIT_TABLE_BYTES)))
    else $error("init-table result with out-of-range target");

  a_res_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> (msg.done && msg.crc_ok))
    else $error("result raised without a complete checked message");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_res_r)))
    else $error("held result changed while stalled");

endmodule

// File: tb/tb_sync_framed_command_receiver_unit.sv
// Self-checking testbench for the framed command receiver: directed and random byte traffic.
`timescale 1ns / 1ps

module tb_sync_framed_command_receiver_unit;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_action;
  logic [7:0]  out_target;
  logic [31:0] out_data_value;
  logic        out_acknowledge;

  sync_framed_command_receiver_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_action(out_action),
    .out_target(out_target),
    .out_data_value(out_data_value),
    .out_acknowledge(out_acknowledge)
  );

  always #5 clk = ~clk;

  sfcr_pkg::result_t expected_actions[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_req = 0;
  int          hold_left = 0;
  int          bytes_sent = 0;

  // Shadow copy of the receiver's framing and sequence state.
  logic [31:0] shadow_hist;
  logic        shadow_synced;
  logic [3:0]  shadow_pos;
  logic [7:0]  shadow_msg [8];
  logic [7:0]  shadow_last_seq;

  function automatic logic [15:0] message_crc(input logic [7:0] body [8]);
    logic [15:0] acc;
    acc = 16'h0000;
    for (int i = 0; i < sfcr_pkg::BODY_LEN; i++) begin
      for (int j = 0; j < 8; j++) begin
        if (acc[0] ^ body[i][j]) begin
          acc = {1'b0, acc[15:1]} ^ sfcr_pkg::CRC_POLY;
        end else begin
          acc = {1'b0, acc[15:1]};
        end
      end
    end
    return acc;
  endfunction

  task automatic clear_shadow();
    shadow_hist = 32'h0;
    shadow_synced = 1'b0;
    shadow_pos = 4'd0;
    for (int i = 0; i < 8; i++) begin
      shadow_msg[i] = 8'h00;
    end
    shadow_last_seq = sfcr_pkg::END_MARK;
  endtask

  task automatic decode_message();
    logic [15:0] crc;
    logic [7:0]  cmd;
    logic [7:0]  addr;
    logic [7:0]  seq;
    sfcr_pkg::result_t res;
    logic        emit;
    crc = message_crc(shadow_msg);
    cmd = shadow_msg[0];
    addr = shadow_msg[1];
    seq = shadow_msg[3];
    emit = 1'b1;
    res.target = addr;
    res.data_value = {24'h0, shadow_msg[2]};
    res.acknowledge = 1'b1;
    res.action = sfcr_pkg::ACT_NOP;
    if (shadow_msg[6] != crc[7:0] || shadow_msg[7] != crc[15:8]) begin
      emit = 1'b0;
    end else if (cmd == sfcr_pkg::CMD_CFG_WRITE && addr < sfcr_pkg::CONFIG_ENTRIES) begin
      res.action = sfcr_pkg::ACT_CFG_WRITE;
      res.data_value = {shadow_msg[5], shadow_msg[4], shadow_msg[3], shadow_msg[2]};
    end else if (cmd == sfcr_pkg::CMD_RAW_SEND) begin
      res.action = sfcr_pkg::ACT_RAW_SEND;
    end else if (cmd == sfcr_pkg::CMD_NOP) begin
      res.action = sfcr_pkg::ACT_NOP;
    end else if (cmd == sfcr_pkg::CMD_RESET) begin
      res.action = sfcr_pkg::ACT_RESET;
      res.acknowledge = 1'b0;
    end else if (cmd == sfcr_pkg::CMD_INIT_WRITE && addr < sfcr_pkg::INIT_TABLE_BYTES) begin
      if (seq == 8'h00 || {1'b0, seq} == {1'b0, shadow_last_seq} + 9'd1) begin
        res.action = sfcr_pkg::ACT_INIT_WRITE;
        shadow_last_seq = seq;
        if (shadow_msg[4] == sfcr_pkg::END_MARK) begin
          shadow_last_seq = sfcr_pkg::END_MARK;
          res.acknowledge = 1'b1;
        end else begin
          res.acknowledge = 1'b0;
        end
      end else begin
        emit = 1'b0;
      end
    end else begin
      emit = 1'b0;
    end
    if (emit) begin
      expected_actions.push_back(res);
      if (res.action == sfcr_pkg::ACT_RESET) begin
        clear_shadow();
      end
    end
  endtask

  task automatic track_byte(input logic [7:0] b);
    shadow_hist = {shadow_hist[23:0], b};
    if (shadow_synced) begin
      shadow_msg[shadow_pos[2:0]] = b;
      shadow_pos = shadow_pos + 4'd1;
    end
    if (shadow_hist == sfcr_pkg::HDR_WORD) begin
      shadow_synced = 1'b1;
      shadow_pos = 4'd0;
    end
    if (shadow_synced && shadow_pos >= 4'd8) begin
      shadow_synced = 1'b0;
      shadow_pos = 4'd0;
      decode_message();
    end
  endtask

  // Offers one word and returns at the edge that accepts it; valid stays high.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do begin
      @(posedge clk);
    end while (in_stall);
    track_byte(b);
    bytes_sent++;
  endtask

  task automatic send_header();
    send_byte(sfcr_pkg::HDR_WORD[31:24]);
    send_byte(sfcr_pkg::HDR_WORD[23:16]);
    send_byte(sfcr_pkg::HDR_WORD[15:8]);
    send_byte(sfcr_pkg::HDR_WORD[7:0]);
  endtask

  task automatic send_message(input logic [7:0] cmd, input logic [7:0] addr,
                              input logic [31:0] value, input bit bad_crc);
    logic [7:0]  body [8];
    logic [15:0] crc;
    body[0] = cmd;
    body[1] = addr;
    body[2] = value[7:0];
    body[3] = value[15:8];
    body[4] = value[23:16];
    body[5] = value[31:24];
    body[6] = 8'h00;
    body[7] = 8'h00;
    crc = message_crc(body);
    if (bad_crc) begin
      crc = crc ^ (16'h1 << $urandom_range(15));
    end
    body[6] = crc[7:0];
    body[7] = crc[15:8];
    send_header();
    for (int i = 0; i < 8; i++) begin
      send_byte(body[i]);
    end
  endtask

  function automatic logic [31:0] init_value(input logic [7:0] v0, input logic [7:0] seq,
                                             input logic [7:0] v2);
    return {8'($urandom_range(255)), v2, seq, v0};
  endfunction

  always @(posedge clk) begin
    sfcr_pkg::result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_actions.size() == 0) begin
        $display("%0t: unexpected result action=%0d target=%0h data=%0h ack=%0b", $time,
                 out_action, out_target, out_data_value, out_acknowledge);
        mismatches++;
      end else begin
        exp_res = expected_actions.pop_front();
        if (out_action !== exp_res.action) begin
          $display("%0t: action expected %0d actual %0d", $time, exp_res.action, out_action);
          mismatches++;
        end
        if (out_target !== exp_res.target) begin
          $display("%0t: target expected %0h actual %0h", $time, exp_res.target, out_target);
          mismatches++;
        end
        if (out_data_value !== exp_res.data_value) begin
          $display("%0t: data_value expected %0h actual %0h", $time, exp_res.data_value,
                   out_data_value);
          mismatches++;
        end
        if (out_acknowledge !== exp_res.acknowledge) begin
          $display("%0t: acknowledge expected %0b actual %0b", $time, exp_res.acknowledge,
                   out_acknowledge);
          mismatches++;
        end
      end
    end
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic test_config_writes();
    send_message(sfcr_pkg::CMD_CFG_WRITE, 8'd0, 32'h0000_0000, 1'b0);
    send_message(sfcr_pkg::CMD_CFG_WRITE, 8'(sfcr_pkg::CONFIG_ENTRIES - 1), 32'hFFFF_FFFF,
                 1'b0);
    send_message(sfcr_pkg::CMD_CFG_WRITE, 8'd2, 32'hA55A_3CC3, 1'b0);
    send_message(sfcr_pkg::CMD_CFG_WRITE, 8'(sfcr_pkg::CONFIG_ENTRIES), 32'h1234_5678, 1'b0);
    send_message(sfcr_pkg::CMD_CFG_WRITE, 8'hFF, 32'h8765_4321, 1'b0);
  endtask

  task automatic test_bus_and_nop();
    send_message(sfcr_pkg::CMD_RAW_SEND, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    send_message(sfcr_pkg::CMD_RAW_SEND, 8'h00, 32'h0000_0000, 1'b0);
    send_message(sfcr_pkg::CMD_NOP, 8'h80, 32'h0102_0380, 1'b0);
  endtask

  task automatic test_init_table();
    send_message(sfcr_pkg::CMD_INIT_WRITE, 8'd0, {8'h00, 8'h00, 8'h00, 8'h00}, 1'b0);
    send_message(sfcr_pkg::CMD_INIT_WRITE, 8'(sfcr_pkg::INIT_TABLE_BYTES - 1),
                 {8'hFF, 8'h55, 8'h01, 8'hFF}, 1'b0);
    send_message(sfcr_pkg::CMD_INIT_WRITE, 8'd5, {8'h00, 8'h00, 8'h03, 8'h11}, 1'b0);
    send_message(sfcr_pkg::CMD_INIT_WRITE, 8'd6, {8'h00, sfcr_pkg::END_MARK, 8'h02, 8'h22},
                 1'b0);
    send_message(sfcr_pkg::CMD_INIT_WRITE, 8'd7, {8'h00, 8'h00, 8'h03, 8'h33}, 1'b0);
    send_message(sfcr_pkg::CMD_INIT_WRITE, 8'(sfcr_pkg::INIT_TABLE_BYTES),
                 {8'h00, 8'h00, 8'h00, 8'h44}, 1'b0);
  endtask

  task automatic test_reject_cases();
    send_message(8'h00, 8'd1, 32'h0000_0001, 1'b0);
    send_message(8'hFF, 8'd1, 32'h0000_0001, 1'b0);
    send_message(sfcr_pkg::CMD_NOP, 8'd1, 32'h0000_0001, 1'b1);
    // A second header lands exactly on the last byte of a message and wins.
    send_header();
    for (int i = 0; i < 4; i++) begin
      send_byte(8'(i + 1));
    end
    send_message(sfcr_pkg::CMD_RAW_SEND, 8'h3C, 32'h0000_00C3, 1'b0);
  endtask

  task automatic test_reset_command();
    send_message(sfcr_pkg::CMD_INIT_WRITE, 8'd9, {8'h00, 8'h00, 8'h00, 8'h99}, 1'b0);
    send_message(sfcr_pkg::CMD_RESET, 8'h42, 32'h0000_00BD, 1'b0);
    send_message(sfcr_pkg::CMD_INIT_WRITE, 8'd10, {8'h00, 8'h00, 8'h01, 8'hAA}, 1'b0);
  endtask

  task automatic test_back_pressure();
    hold_req = 300;
    for (int i = 0; i < 6; i++) begin
      send_message(sfcr_pkg::CMD_RAW_SEND, 8'(i), 32'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic random_message(input bit bad_crc);
    logic [7:0]  cmd;
    logic [7:0]  addr;
    logic [7:0]  seq;
    logic [7:0]  v2;
    logic [31:0] value;
    int          pick;
    pick = $urandom_range(19);
    value = $urandom;
    if (pick < 5) begin
      cmd = sfcr_pkg::CMD_CFG_WRITE;
      addr = ($urandom_range(3) == 0) ? 8'($urandom) :
             8'($urandom_range(sfcr_pkg::CONFIG_ENTRIES));
    end else if (pick < 8) begin
      cmd = sfcr_pkg::CMD_RAW_SEND;
      addr = 8'($urandom);
    end else if (pick < 10) begin
      cmd = sfcr_pkg::CMD_NOP;
      addr = 8'($urandom);
    end else if (pick < 11) begin
      cmd = sfcr_pkg::CMD_RESET;
      addr = 8'($urandom);
    end else if (pick < 18) begin
      cmd = sfcr_pkg::CMD_INIT_WRITE;
      addr = ($urandom_range(4) == 0) ? 8'($urandom) :
             8'($urandom_range(sfcr_pkg::INIT_TABLE_BYTES));
      pick = $urandom_range(9);
      if (pick < 6) begin
        seq = shadow_last_seq + 8'd1;
      end else if (pick < 8) begin
        seq = 8'h00;
      end else begin
        seq = 8'($urandom);
      end
      v2 = ($urandom_range(6) == 0) ? sfcr_pkg::END_MARK : 8'($urandom);
      value = init_value(value[7:0], seq, v2);
    end else begin
      cmd = 8'($urandom);
      addr = 8'($urandom);
    end
    send_message(cmd, addr, value, bad_crc);
  endtask

  task automatic random_noise();
    int n;
    int pick;
    n = $urandom_range(12, 1);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(5);
      case (pick)
        0: begin
          send_byte(sfcr_pkg::HDR_WORD[31:24]);
        end
        1: begin
          send_byte(sfcr_pkg::HDR_WORD[15:8]);
        end
        2: begin
          send_byte(sfcr_pkg::HDR_WORD[7:0]);
        end
        default: begin
          send_byte(8'($urandom));
        end
      endcase
    end
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_bytes);
    int stop_at;
    int pick;
    int k;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        random_message(1'b0);
      end else if (pick < 80) begin
        random_message(1'b1);
      end else if (pick < 90) begin
        send_header();
        k = $urandom_range(7);
        for (int i = 0; i < k; i++) begin
          send_byte(8'($urandom));
        end
        random_message(1'b0);
      end else begin
        random_noise();
      end
    end
  endtask

  initial begin
    clear_shadow();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 15;
    recv_idle_pct = 55;
    test_config_writes();
    test_bus_and_nop();
    test_init_table();
    test_reject_cases();
    test_reset_command();
    send_idle_pct = 0;
    test_back_pressure();
    test_random_traffic(15, 55, 460);
    test_random_traffic(55, 15, 460);
    test_random_traffic(0, 0, 460);
    in_valid <= 1'b0;
    while (expected_actions.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_actions.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
sv/sfcr_pkg.sv
sv/sfcr_frame.sv
sv/sfcr_decode.sv
sv/sync_framed_command_receiver_unit.sv
tb/tb_sync_framed_command_receiver_unit.sv
